// ----- src/pam_pkg.sv -----
// ----------------------------------------------------------------------------
// pam_pkg: shared types and constants for the polygon area membership unit
// Coordinate widths, register indexes, basement rectangle and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pam_pkg;

    localparam int COORD_W      = 24;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int SUM_W        = PROD_W + 1;
    localparam int MAX_VERTICES = 16;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);
    localparam int IN_IDX_W     = 4;
    localparam int MAP_W        = 16;
    localparam int ZONE_W       = 24;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 24;
    localparam int RECT_IDX_W   = 2;
    localparam int RECT_LAST    = 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_HOME_MAP     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BASEMENT_MAP = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_AREA_IDENT   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_USE_HEIGHT   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT_MIN   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT_MAX   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X     = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y     = 3'd7;

    // basement window, z in [1.0, 9.0] Q15.8
    localparam coord_t BASE_ZMIN = 24'sd256;
    localparam coord_t BASE_ZMAX = 24'sd2304;

    // basement rectangle corners: SE, SW, NW, NE
    localparam coord_t RECT_X [4] = '{-24'sd67411, -24'sd71909, -24'sd71909, -24'sd67411};
    localparam coord_t RECT_Y [4] = '{-24'sd67097, -24'sd67097, -24'sd62562, -24'sd62562};

    typedef struct packed {
        logic              load;
        logic              latch;
        logic              clear_par;
        logic              rd_en;
        logic              rd_prime;
        logic              rect_sel;
        logic [VIDX_W-1:0] rd_addr;
    } pam_cmd_t;

    typedef struct packed {
        logic              home_hit;
        logic              height_ok;
        logic              base_ok;
        logic [VCNT_W-1:0] vcount;
        logic              pipe_busy;
        logic              parity;
    } pam_status_t;

endpackage

`default_nettype wire

// ----- src/pam_ctrl.sv -----
// ----------------------------------------------------------------------------
// pam_ctrl: request sequencer
// Accepts requests, picks home or basement test, steps the edge walk and
// reports the result once the crossing pipeline has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module pam_ctrl
    import pam_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        opcode,
    input  wire pam_status_t st,
    output pam_cmd_t         cmd,
    output logic             busy,
    output logic             done,
    output logic             inside_res,
    output logic             via_basement
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PRIME,
        ST_WALK,
        ST_DRAIN
    } state_t;

    state_t            state_reg;
    logic [VIDX_W-1:0] cnt_reg;
    logic [VIDX_W-1:0] last_reg;
    logic              rect_reg;
    logic              done_reg;
    logic              inside_reg;
    logic              via_reg;

    logic              accept;
    logic [VCNT_W-1:0] vc_m1;

    assign accept = start && (state_reg == ST_IDLE);
    assign vc_m1  = st.vcount - VCNT_W'(1);

    always_comb
    begin
        cmd           = '0;
        cmd.load      = accept && (opcode == OP_LOAD);
        cmd.latch     = accept && (opcode == OP_QUERY);
        cmd.clear_par = (state_reg == ST_DECIDE);
        cmd.rect_sel  = rect_reg;
        cmd.rd_en     = (state_reg == ST_PRIME) || (state_reg == ST_WALK);
        cmd.rd_prime  = (state_reg == ST_PRIME);
        cmd.rd_addr   = (state_reg == ST_PRIME) ? last_reg : cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            last_reg   <= '0;
            rect_reg   <= 1'b0;
            done_reg   <= 1'b0;
            inside_reg <= 1'b0;
            via_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start && (opcode == OP_QUERY))
                        state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    // home map wins over basement when both ids match
                    if (st.home_hit)
                    begin
                        if (st.height_ok && (st.vcount != '0))
                        begin
                            rect_reg  <= 1'b0;
                            last_reg  <= vc_m1[VIDX_W-1:0];
                            state_reg <= ST_PRIME;
                        end
                        else
                        begin
                            done_reg   <= 1'b1;
                            inside_reg <= 1'b0;
                            via_reg    <= 1'b0;
                            state_reg  <= ST_IDLE;
                        end
                    end
                    else if (st.base_ok)
                    begin
                        rect_reg  <= 1'b1;
                        last_reg  <= VIDX_W'(RECT_LAST);
                        state_reg <= ST_PRIME;
                    end
                    else
                    begin
                        done_reg   <= 1'b1;
                        inside_reg <= 1'b0;
                        via_reg    <= 1'b0;
                        state_reg  <= ST_IDLE;
                    end
                end
                ST_PRIME:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_WALK;
                end
                ST_WALK:
                begin
                    if (cnt_reg == last_reg)
                        state_reg <= ST_DRAIN;
                    else
                        cnt_reg <= cnt_reg + VIDX_W'(1);
                end
                ST_DRAIN:
                begin
                    if (!st.pipe_busy)
                    begin
                        done_reg   <= 1'b1;
                        inside_reg <= st.parity;
                        via_reg    <= st.parity && rect_reg;
                        state_reg  <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign inside_res   = inside_reg;
    assign via_basement = via_reg;

endmodule

`default_nettype wire

// ----- src/pam_datapath.sv -----
// ----------------------------------------------------------------------------
// pam_datapath: registers, vertex memory and edge crossing pipeline
// One edge enters per cycle: read, differences, products, determinants,
// then the crossing decision toggles the parity bit.
// ----------------------------------------------------------------------------
`default_nettype none

module pam_datapath
    import pam_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pam_cmd_t              cmd,
    output pam_status_t                st,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [IN_IDX_W-1:0]   vertex_index,
    input  wire logic                  vertex_last,
    input  wire logic signed [COORD_W-1:0] coord_x,
    input  wire logic signed [COORD_W-1:0] coord_y,
    input  wire logic signed [COORD_W-1:0] coord_z,
    input  wire logic [MAP_W-1:0]      map_ident,
    input  wire logic [ZONE_W-1:0]     zone_ident
);

    // configuration
    logic [MAP_W-1:0]  home_map_reg;
    logic [MAP_W-1:0]  basement_map_reg;
    logic [ZONE_W-1:0] area_ident_reg;
    logic              use_height_reg;
    coord_t            height_min_reg;
    coord_t            height_max_reg;
    coord_t            origin_x_reg;
    coord_t            origin_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_map_reg     <= '0;
            basement_map_reg <= '0;
            area_ident_reg   <= '0;
            use_height_reg   <= 1'b0;
            height_min_reg   <= '0;
            height_max_reg   <= '0;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_HOME_MAP:     home_map_reg     <= cfg_wdata[MAP_W-1:0];
                REG_BASEMENT_MAP: basement_map_reg <= cfg_wdata[MAP_W-1:0];
                REG_AREA_IDENT:   area_ident_reg   <= cfg_wdata[ZONE_W-1:0];
                REG_USE_HEIGHT:   use_height_reg   <= cfg_wdata[0];
                REG_HEIGHT_MIN:   height_min_reg   <= cfg_wdata[COORD_W-1:0];
                REG_HEIGHT_MAX:   height_max_reg   <= cfg_wdata[COORD_W-1:0];
                REG_ORIGIN_X:     origin_x_reg     <= cfg_wdata[COORD_W-1:0];
                REG_ORIGIN_Y:     origin_y_reg     <= cfg_wdata[COORD_W-1:0];
                default:          ;
            endcase
        end
    end

    // vertex count
    logic [VCNT_W-1:0] vcount_reg;
    logic              load_ok;

    assign load_ok = VCNT_W'(vertex_index) < VCNT_W'(MAX_VERTICES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vcount_reg <= '0;
        else if (cmd.load && load_ok && vertex_last)
            vcount_reg <= VCNT_W'(vertex_index) + VCNT_W'(1);
    end

    // vertex memory, single read port with registered data
    coord_t mem_x [MAX_VERTICES];
    coord_t mem_y [MAX_VERTICES];
    coord_t rd_x_reg;
    coord_t rd_y_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load && load_ok)
        begin
            mem_x[VIDX_W'(vertex_index)] <= coord_x;
            mem_y[VIDX_W'(vertex_index)] <= coord_y;
        end
        if (cmd.rect_sel)
        begin
            rd_x_reg <= RECT_X[cmd.rd_addr[RECT_IDX_W-1:0]];
            rd_y_reg <= RECT_Y[cmd.rd_addr[RECT_IDX_W-1:0]];
        end
        else
        begin
            rd_x_reg <= mem_x[cmd.rd_addr];
            rd_y_reg <= mem_y[cmd.rd_addr];
        end
    end

    // query point
    coord_t            q_x_reg;
    coord_t            q_y_reg;
    coord_t            q_z_reg;
    logic [MAP_W-1:0]  q_map_reg;
    logic [ZONE_W-1:0] q_zone_reg;
    diff_t             d2x_reg;
    diff_t             d2y_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            q_x_reg    <= coord_x;
            q_y_reg    <= coord_y;
            q_z_reg    <= coord_z;
            q_map_reg  <= map_ident;
            q_zone_reg <= zone_ident;
        end
        // settles in the decide cycle, before any edge reaches the products
        d2x_reg <= DIFF_W'(q_x_reg) - DIFF_W'(origin_x_reg);
        d2y_reg <= DIFF_W'(q_y_reg) - DIFF_W'(origin_y_reg);
    end

    // pipeline control
    logic s0_v_reg, s0_prime_reg, s1_v_reg, s2_v_reg, s3_v_reg;
    logic parity_reg;
    logic is_crossing;

    // stage payloads
    coord_t prev_x_reg, prev_y_reg;
    diff_t  d1x_reg, d1y_reg, ax_reg, ay_reg;
    prod_t  p_d1_reg, p_d2_reg, p_s1_reg, p_s2_reg, p_t1_reg, p_t2_reg;
    sum_t   den_reg, ns_reg, nt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg     <= 1'b0;
            s0_prime_reg <= 1'b0;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            s3_v_reg     <= 1'b0;
            parity_reg   <= 1'b0;
        end
        else
        begin
            s0_v_reg     <= cmd.rd_en;
            s0_prime_reg <= cmd.rd_prime;
            s1_v_reg     <= s0_v_reg && !s0_prime_reg;
            s2_v_reg     <= s1_v_reg;
            s3_v_reg     <= s2_v_reg;
            if (cmd.clear_par)
                parity_reg <= 1'b0;
            else if (s3_v_reg && is_crossing)
                parity_reg <= !parity_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_v_reg)
        begin
            // edge runs from current vertex S to previous vertex E
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
            d1x_reg    <= DIFF_W'(prev_x_reg) - DIFF_W'(rd_x_reg);
            d1y_reg    <= DIFF_W'(prev_y_reg) - DIFF_W'(rd_y_reg);
            ax_reg     <= DIFF_W'(rd_x_reg) - DIFF_W'(origin_x_reg);
            ay_reg     <= DIFF_W'(rd_y_reg) - DIFF_W'(origin_y_reg);
        end
        p_d1_reg <= d1x_reg * d2y_reg;
        p_d2_reg <= d2x_reg * d1y_reg;
        p_s1_reg <= d1x_reg * ay_reg;
        p_s2_reg <= d1y_reg * ax_reg;
        p_t1_reg <= d2x_reg * ay_reg;
        p_t2_reg <= d2y_reg * ax_reg;
        den_reg  <= SUM_W'(p_d1_reg) - SUM_W'(p_d2_reg);
        ns_reg   <= SUM_W'(p_s1_reg) - SUM_W'(p_s2_reg);
        nt_reg   <= SUM_W'(p_t1_reg) - SUM_W'(p_t2_reg);
    end

    // both parameters within [0, 1]; a negative determinant flips the window
    always_comb
    begin
        if (den_reg == '0)
            is_crossing = 1'b0;
        else if (den_reg > 0)
            is_crossing = (ns_reg >= 0) && (ns_reg <= den_reg) &&
                          (nt_reg >= 0) && (nt_reg <= den_reg);
        else
            is_crossing = (ns_reg <= 0) && (ns_reg >= den_reg) &&
                          (nt_reg <= 0) && (nt_reg >= den_reg);
    end

    // status
    assign st.home_hit  = (q_map_reg == home_map_reg);
    assign st.height_ok = !use_height_reg ||
                          ((q_z_reg >= height_min_reg) && (q_z_reg <= height_max_reg));
    assign st.base_ok   = (q_map_reg == basement_map_reg) &&
                          (q_zone_reg == area_ident_reg) &&
                          (q_z_reg >= BASE_ZMIN) && (q_z_reg <= BASE_ZMAX);
    assign st.vcount    = vcount_reg;
    assign st.pipe_busy = s0_v_reg || s1_v_reg || s2_v_reg || s3_v_reg;
    assign st.parity    = parity_reg;

endmodule

`default_nettype wire

// ----- src/polygon_area_membership_unit.sv -----
// ----------------------------------------------------------------------------
// polygon_area_membership_unit: point in polygon zone test
// Crossing-number test of a point against a loaded vertex table, with a
// height window on the home map and a fixed rectangle on the basement map.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  request   start / busy     opcode, vertex_index, vertex_last, coord_x/y/z,
//                             map_ident, zone_ident
//  result    done (1 cycle)   inside_res, via_basement
//  config    cfg_we           cfg_addr, cfg_wdata
//
//  A load request completes at its accept edge, busy stays low.
//  A query walks the n table edges, a basement query the four rectangle edges;
//  some queries are decided without a walk. Edges go one per cycle through the
//  single vertex memory read port into the crossing pipeline of read, difference,
//  product and determinant stages. One query at a time; busy is high until done.
//  Reset clears control, config and vertex count; vertex memory is not cleared.
//  Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_area_membership_unit
    import pam_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      opcode,
    input  wire logic [IN_IDX_W-1:0]       vertex_index,
    input  wire logic                      vertex_last,
    input  wire logic signed [COORD_W-1:0] coord_x,
    input  wire logic signed [COORD_W-1:0] coord_y,
    input  wire logic signed [COORD_W-1:0] coord_z,
    input  wire logic [MAP_W-1:0]          map_ident,
    input  wire logic [ZONE_W-1:0]         zone_ident,
    output logic                           done,
    output logic                           inside_res,
    output logic                           via_basement,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]     cfg_wdata
);

    pam_cmd_t    cmd;
    pam_status_t st;

    pam_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .opcode       (opcode),
        .st           (st),
        .cmd          (cmd),
        .busy         (busy),
        .done         (done),
        .inside_res   (inside_res),
        .via_basement (via_basement)
    );

    pam_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .vertex_index (vertex_index),
        .vertex_last  (vertex_last),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .map_ident    (map_ident),
        .zone_ident   (zone_ident)
    );

    // result cycle always returns to idle
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_via_implies_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (done && via_basement) |-> inside_res)
        else $error("basement hit without inside");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == OP_QUERY)) |=> busy)
        else $error("query accepted but not busy");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == OP_LOAD)) |=> (!busy && !done))
        else $error("load started a walk");

    a_walk_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (!done && busy))
        else $error("result during edge walk");

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for polygon_area_membership_unit
// Sends vertex loads and point queries over the start/busy port. An exact
// integer crossing-number predictor computes each membership answer, and
// every done strobe is checked against the oldest pending answer. Directed
// corner cases come first, then random zones under changing register settings.
// ----------------------------------------------------------------------------
module tb;
    import pam_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int MAX_REPORTS    = 100;

    typedef struct {
        logic                op;
        logic [IN_IDX_W-1:0] idx;
        logic                last;
        coord_t              x;
        coord_t              y;
        coord_t              z;
        logic [MAP_W-1:0]    map;
        logic [ZONE_W-1:0]   zone;
    } request_t;

    typedef struct packed {
        logic in_zone;
        logic via;
    } membership_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  opcode;
    logic [IN_IDX_W-1:0]   vertex_index;
    logic                  vertex_last;
    coord_t                coord_x;
    coord_t                coord_y;
    coord_t                coord_z;
    logic [MAP_W-1:0]      map_ident;
    logic [ZONE_W-1:0]     zone_ident;
    logic                  done;
    logic                  inside_res;
    logic                  via_basement;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // register and table copies used for prediction
    logic [MAP_W-1:0]        home_map_r;
    logic [MAP_W-1:0]        basement_map_r;
    logic [ZONE_W-1:0]       area_ident_r;
    logic                    use_height_r;
    coord_t                  height_min_r;
    coord_t                  height_max_r;
    coord_t                  origin_x_r;
    coord_t                  origin_y_r;
    coord_t                  poly_x [MAX_VERTICES];
    coord_t                  poly_y [MAX_VERTICES];
    logic [VCNT_W-1:0]       poly_count;
    logic [MAX_VERTICES-1:0] slot_loaded;

    membership_t expected_membership[$];
    membership_t oldest;
    int          errors;
    int          idle_cycles;
    int          sent_items;
    int          calm_left;

    polygon_area_membership_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .vertex_index (vertex_index),
        .vertex_last  (vertex_last),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .map_ident    (map_ident),
        .zone_ident   (zone_ident),
        .done         (done),
        .inside_res   (inside_res),
        .via_basement (via_basement),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic bit ray_crosses_edge(longint sx, longint sy, longint ex, longint ey,
                                            longint px, longint py);
        longint d1x, d1y, d2x, d2y, ax, ay, den, ns, nt;
        d1x = ex - sx;
        d1y = ey - sy;
        d2x = px - longint'(origin_x_r);
        d2y = py - longint'(origin_y_r);
        ax  = sx - longint'(origin_x_r);
        ay  = sy - longint'(origin_y_r);
        den = d1x * d2y - d2x * d1y;
        ns  = d1x * ay - d1y * ax;
        nt  = d2x * ay - d2y * ax;
        // parallel or zero-length edge: no crossing
        if (den == 0)
            return 1'b0;
        if (den < 0)
        begin
            den = -den;
            ns  = -ns;
            nt  = -nt;
        end
        return ns >= 0 && ns <= den && nt >= 0 && nt <= den;
    endfunction

    function automatic membership_t predict_membership(request_t r);
        membership_t res;
        int          hits;
        int          n;
        int          j;
        res  = '0;
        hits = 0;
        if (r.map != home_map_r)
        begin
            if (r.map == basement_map_r && r.zone == area_ident_r &&
                r.z >= BASE_ZMIN && r.z <= BASE_ZMAX)
            begin
                for (int i = 0; i <= RECT_LAST; i++)
                begin
                    j = (i == 0) ? RECT_LAST : i - 1;
                    if (ray_crosses_edge(RECT_X[i], RECT_Y[i], RECT_X[j], RECT_Y[j], r.x, r.y))
                        hits++;
                end
                res.in_zone = hits[0];
                res.via     = hits[0];
            end
        end
        else if (!(use_height_r && (r.z < height_min_r || r.z > height_max_r)))
        begin
            n = int'(poly_count);
            for (int i = 0; i < n; i++)
            begin
                j = (i == 0) ? n - 1 : i - 1;
                if (ray_crosses_edge(poly_x[i], poly_y[i], poly_x[j], poly_y[j], r.x, r.y))
                    hits++;
            end
            res.in_zone = hits[0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // request builders and drivers
    // ------------------------------------------------------------------
    function automatic coord_t clip_coord(longint v);
        if (v > 64'sd8388607)
            return 24'sd8388607;
        if (v < -64'sd8388608)
            return -24'sd8388608;
        return coord_t'(v);
    endfunction

    function automatic request_t vertex_load(int idx, longint x, longint y, bit last);
        request_t r;
        r.op   = OP_LOAD;
        r.idx  = IN_IDX_W'(idx);
        r.last = last;
        r.x    = clip_coord(x);
        r.y    = clip_coord(y);
        r.z    = coord_t'($urandom);
        r.map  = MAP_W'($urandom);
        r.zone = ZONE_W'($urandom);
        return r;
    endfunction

    function automatic request_t point_query(longint x, longint y, longint z,
                                             logic [MAP_W-1:0] map, logic [ZONE_W-1:0] zone);
        request_t r;
        r.op   = OP_QUERY;
        r.idx  = IN_IDX_W'($urandom);
        r.last = 1'($urandom);
        r.x    = clip_coord(x);
        r.y    = clip_coord(y);
        r.z    = clip_coord(z);
        r.map  = map;
        r.zone = zone;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic send_request(request_t r);
        int gap;
        int roll;
        @(negedge clk);
        start        <= 1'b1;
        opcode       <= r.op;
        vertex_index <= r.idx;
        vertex_last  <= r.last;
        coord_x      <= r.x;
        coord_y      <= r.y;
        coord_z      <= r.z;
        map_ident    <= r.map;
        zone_ident   <= r.zone;
        do
            @(posedge clk);
        while (busy);
        if (r.op == OP_QUERY)
            expected_membership.insert(expected_membership.size(), predict_membership(r));
        else
        begin
            poly_x[r.idx]      = r.x;
            poly_y[r.idx]      = r.y;
            slot_loaded[r.idx] = 1'b1;
            if (r.last)
                poly_count = VCNT_W'(r.idx) + VCNT_W'(1);
        end
        sent_items++;

        if (calm_left > 0)
        begin
            calm_left--;
            gap = 0;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
            begin
                calm_left = $urandom_range(15, 40);
                gap = 0;
            end
            else if (roll < 45)
                gap = 0;
            else if (roll < 85)
                gap = $urandom_range(1, 3);
            else if (roll < 96)
                gap = $urandom_range(4, 12);
            else
                gap = $urandom_range(20, 45);
        end
        // gap 0 keeps start high into the next request
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // drop start, wait for all answers, then wait for trailing loads
    task automatic settle_block();
        @(negedge clk);
        start <= 1'b0;
        while (expected_membership.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            REG_HOME_MAP:     home_map_r     = data[MAP_W-1:0];
            REG_BASEMENT_MAP: basement_map_r = data[MAP_W-1:0];
            REG_AREA_IDENT:   area_ident_r   = data[ZONE_W-1:0];
            REG_USE_HEIGHT:   use_height_r   = data[0];
            REG_HEIGHT_MIN:   height_min_r   = coord_t'(data);
            REG_HEIGHT_MAX:   height_max_r   = coord_t'(data);
            REG_ORIGIN_X:     origin_x_r     = coord_t'(data);
            REG_ORIGIN_Y:     origin_y_r     = coord_t'(data);
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result checking and watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((start && !busy) || done || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;

            if (done)
            begin
                if (expected_membership.size() == 0)
                    report_mismatch($sformatf("result with nothing pending: inside %0b via %0b",
                                              inside_res, via_basement));
                else
                begin
                    oldest = expected_membership.pop_front();
                    if (inside_res !== oldest.in_zone || via_basement !== oldest.via)
                        report_mismatch($sformatf("inside %0b via %0b, expected %0b %0b",
                                                  inside_res, via_basement,
                                                  oldest.in_zone, oldest.via));
                end
            end

            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no progress, %0d answers pending",
                         $time, expected_membership.size());
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_empty_table();
        // after reset map 0 is home with no vertices: always outside
        send_request(point_query(0, 0, 0, 16'h0000, 24'h000000));
        send_request(point_query(8388607, -8388608, -8388608, 16'hFFFF, 24'hFFFFFF));
    endtask

    task automatic test_square_zone();
        settle_block();
        write_register(REG_ORIGIN_X, 24'(-4000));
        write_register(REG_ORIGIN_Y, 24'(-1000));
        send_request(vertex_load(0, -1000, -1000, 1'b0));
        send_request(vertex_load(1, 1000, -1000, 1'b0));
        send_request(vertex_load(2, 1000, 1000, 1'b0));
        send_request(vertex_load(3, -1000, 1000, 1'b1));
        send_request(point_query(0, 0, 0, 16'h0000, 24'h0));
        send_request(point_query(5000, 0, 0, 16'h0000, 24'h0));
        // ray runs along the bottom edge
        send_request(point_query(0, -1000, 0, 16'h0000, 24'h0));
        send_request(point_query(1000, 1000, 0, 16'h0000, 24'h0));
        send_request(point_query(8388607, 8388607, 8388607, 16'h0000, 24'h0));
        send_request(point_query(-8388608, -8388608, -8388608, 16'h0000, 24'h0));
    endtask

    task automatic test_degenerate_and_reload();
        // zero-length edge between slots 1 and 0
        send_request(vertex_load(1, -1000, -1000, 1'b0));
        send_request(point_query(0, 0, 0, 16'h0000, 24'h0));
        // last mark on a lower slot shrinks the table to a triangle
        send_request(vertex_load(2, -8388608, 8388607, 1'b1));
        send_request(point_query(0, 500, 0, 16'h0000, 24'h0));
    endtask

    task automatic test_height_window();
        settle_block();
        write_register(REG_USE_HEIGHT, 24'd1);
        write_register(REG_HEIGHT_MIN, 24'(-256));
        write_register(REG_HEIGHT_MAX, 24'(512));
        send_request(point_query(-900, 0, -256, 16'h0000, 24'h0));
        send_request(point_query(-900, 0, 512, 16'h0000, 24'h0));
        send_request(point_query(-900, 0, 513, 16'h0000, 24'h0));
        settle_block();
        // min above max: nothing on the home map is inside
        write_register(REG_HEIGHT_MIN, 24'(100));
        write_register(REG_HEIGHT_MAX, 24'(-100));
        send_request(point_query(-900, 0, 0, 16'h0000, 24'h0));
    endtask

    task automatic test_basement();
        settle_block();
        write_register(REG_BASEMENT_MAP, 24'd7);
        write_register(REG_AREA_IDENT, 24'hABCDEF);
        send_request(point_query(-69000, -65000, 256, 16'd7, 24'hABCDEF));
        send_request(point_query(-69000, -65000, 2305, 16'd7, 24'hABCDEF));
        send_request(point_query(-69000, -65000, 500, 16'd7, 24'hABCDEE));
        send_request(point_query(-60000, -65000, 500, 16'd7, 24'hABCDEF));
        settle_block();
        // basement id equal to home id: home test wins
        write_register(REG_BASEMENT_MAP, 24'd0);
        send_request(point_query(-69000, -65000, 256, 16'd0, 24'hABCDEF));
    endtask

    task automatic test_random_zones();
        int                phase;
        int                stop_at;
        int                n;
        int                k;
        int                roll;
        int                need_mask;
        logic [MAP_W-1:0]  home;
        logic [ZONE_W-1:0] zone;
        longint            span;
        longint            lim;
        longint            cx;
        longint            cy;
        longint            hmin;
        longint            hmax;
        longint            pz;
        phase   = 0;
        stop_at = sent_items + RANDOM_ITEMS;
        while (sent_items < stop_at)
        begin
            settle_block();

            home = (phase % 4 == 1) ? 16'hFFFF : 16'($urandom_range(0, 3));
            write_register(REG_HOME_MAP, {8'($urandom), home});
            write_register(REG_BASEMENT_MAP,
                           (phase % 7 == 3) ? {8'($urandom), home} : 24'($urandom));
            case (phase % 4)
                1:       write_register(REG_AREA_IDENT, 24'hFFFFFF);
                2:       write_register(REG_AREA_IDENT, 24'h000000);
                default: write_register(REG_AREA_IDENT, 24'($urandom));
            endcase
            write_register(REG_USE_HEIGHT, {23'($urandom), ($urandom_range(0, 2) != 0)});
            hmin = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
            case (phase % 4)
                1:
                begin
                    hmin = -8388608;
                    hmax = 8388607;
                end
                2:       hmax = hmin;
                3:       hmax = hmin - $urandom_range(1, 1000);
                default: hmax = hmin + $urandom_range(0, 1 << 20);
            endcase
            write_register(REG_HEIGHT_MIN, 24'(hmin));
            write_register(REG_HEIGHT_MAX, 24'(hmax));
            case (phase % 4)
                1:
                begin
                    write_register(REG_ORIGIN_X, 24'h800000);
                    write_register(REG_ORIGIN_Y, 24'h800000);
                end
                2:
                begin
                    write_register(REG_ORIGIN_X, 24'h7FFFFF);
                    write_register(REG_ORIGIN_Y, 24'h800000);
                end
                default:
                begin
                    write_register(REG_ORIGIN_X, 24'($urandom));
                    write_register(REG_ORIGIN_Y, 24'($urandom));
                end
            endcase

            // a fresh polygon: slots 0..n-1, last mark on the top slot
            span = (phase % 4 == 1) ? (1 << 22) : (1 << $urandom_range(6, 20));
            lim  = 8388607 - span;
            cx   = longint'($urandom_range(0, 2 * lim)) - lim;
            cy   = longint'($urandom_range(0, 2 * lim)) - lim;
            if (phase % 8 == 0)
                n = MAX_VERTICES;
            else if ($urandom_range(0, 9) == 0)
                n = $urandom_range(7, MAX_VERTICES);
            else
                n = $urandom_range(3, 6);
            for (int i = 0; i < n; i++)
                send_request(vertex_load(i, cx - span + $urandom_range(0, 2 * span),
                                         cy - span + $urandom_range(0, 2 * span), i == n - 1));

            repeat ($urandom_range(8, 40))
            begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                begin
                    k = $urandom_range(0, MAX_VERTICES - 1);
                    need_mask = (1 << (k + 1)) - 1;
                    send_request(vertex_load(k, cx - span + $urandom_range(0, 2 * span),
                                             cy - span + $urandom_range(0, 2 * span),
                                             (int'(slot_loaded) & need_mask) == need_mask &&
                                             $urandom_range(0, 3) == 0));
                end
                else if (roll < 20)
                begin
                    case ($urandom_range(0, 9))
                        0:       pz = 255;
                        1:       pz = 256;
                        2:       pz = 2304;
                        3:       pz = 2305;
                        default: pz = $urandom_range(0, 2600);
                    endcase
                    zone = ($urandom_range(0, 9) == 0) ? 24'($urandom) : area_ident_r;
                    send_request(point_query(longint'($urandom_range(0, 5098)) - 72209,
                                             longint'($urandom_range(0, 5135)) - 67397,
                                             pz, basement_map_r, zone));
                end
                else if (roll < 25)
                    send_request(point_query(coord_t'($urandom), coord_t'($urandom),
                                             coord_t'($urandom), 16'($urandom), 24'($urandom)));
                else
                begin
                    case ($urandom_range(0, 9))
                        0:       pz = height_min_r;
                        1:       pz = height_max_r;
                        2:       pz = longint'(height_min_r) - 1;
                        3:       pz = longint'(height_max_r) + 1;
                        4:       pz = coord_t'($urandom);
                        default:
                            if (height_min_r <= height_max_r)
                                pz = longint'(height_min_r) +
                                     $urandom_range(0, int'(height_max_r) - int'(height_min_r));
                            else
                                pz = coord_t'($urandom);
                    endcase
                    send_request(point_query(cx - 2 * span + $urandom_range(0, 4 * span),
                                             cy - 2 * span + $urandom_range(0, 4 * span),
                                             pz, home_map_r, 24'($urandom)));
                end
            end
            phase++;
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        errors         = 0;
        sent_items     = 0;
        calm_left      = 0;
        rst_n          = 1'b0;
        start          = 1'b0;
        opcode         = OP_LOAD;
        vertex_index   = '0;
        vertex_last    = 1'b0;
        coord_x        = '0;
        coord_y        = '0;
        coord_z        = '0;
        map_ident      = '0;
        zone_ident     = '0;
        cfg_we         = 1'b0;
        cfg_addr       = REG_HOME_MAP;
        cfg_wdata      = '0;
        home_map_r     = '0;
        basement_map_r = '0;
        area_ident_r   = '0;
        use_height_r   = 1'b0;
        height_min_r   = '0;
        height_max_r   = '0;
        origin_x_r     = '0;
        origin_y_r     = '0;
        poly_count     = '0;
        slot_loaded    = '0;
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            poly_x[i] = '0;
            poly_y[i] = '0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_square_zone();
        test_degenerate_and_reload();
        test_height_window();
        test_basement();
        test_random_zones();

        settle_block();
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/pam_pkg.sv
src/pam_ctrl.sv
src/pam_datapath.sv
src/polygon_area_membership_unit.sv
verif/tb.sv
